// File: hw/rtl/didm_pkg.sv
// ----------------------------------------------------------------------------
// didm_pkg
// Shared types and constants of the discrete input debounce monitor.
// ----------------------------------------------------------------------------
package didm_pkg;

   localparam logic       REQ_PACKET     = 1'b0;
   localparam logic       REQ_TICK       = 1'b1;
   localparam logic [7:0] MIN_PACKET_LEN = 8'd21;
   localparam logic [3:0] DATA_KIND      = 4'd2;
   localparam logic [23:0] ELAPSED_MAX   = 24'hFFFFFF;

   localparam logic [7:0] CSR_DEBOUNCE   = 8'd0;
   localparam logic [7:0] CSR_RESP_TMO   = 8'd1;
   localparam logic [7:0] CSR_ERR_TMO    = 8'd2;
   localparam logic [7:0] CSR_ENABLE     = 8'd3;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd0;
   localparam logic [23:0] RESP_TMO_RESET = 24'd10000;
   localparam logic [23:0] ERR_TMO_RESET  = 24'd30000;

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   typedef enum logic [2:0] {
      MODE_BEGIN   = 3'd0,
      MODE_STEP    = 3'd1,
      MODE_WAIT    = 3'd2,
      MODE_TIMEOUT = 3'd3,
      MODE_ERROR   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ERR_VALID   = 2'd0,
      ERR_INVALID = 2'd1,
      ERR_UNKNOWN = 2'd2
   } err_type;

   // classified request as handed from front to back
   typedef enum logic [2:0] {
      CMD_IGNORE  = 3'd0,
      CMD_CLEAR   = 3'd1,
      CMD_OVERLAP = 3'd2,
      CMD_DATA    = 3'd3,
      CMD_TICK    = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [23:0] response_timeout_ms;
      logic [23:0] error_timeout_ms;
      logic [63:0] signal_enable_mask;
   } cfg_type;

   typedef struct packed {
      logic        publish_valid;
      logic [63:0] signal_states;
      logic        poll_request;
      err_type     error_code;
      logic        error_changed;
      mode_type    mode;
   } rsp_type;

endpackage

// File: hw/rtl/discrete_input_debounce_monitor.sv
// ----------------------------------------------------------------------------
// discrete_input_debounce_monitor
// Debounce and supervision of a double-coded telesignal source.
// ----------------------------------------------------------------------------
// Takes one request (packet or 1 ms tick) per clock while full is low, and
// returns exactly one result per request, in order. A request is classified
// in the front end on the cycle it is pushed and waits in a two-entry queue;
// the mode sequencer handles one request per cycle unless the result queue
// is full, and its result is registered in the result queue before it can be
// popped. Full rises only while the result queue (two entries) backs up.
// Configuration writes are always taken (csr_ready is tied high) and must be
// made while the block is idle.
// ----------------------------------------------------------------------------
module discrete_input_debounce_monitor
   import didm_pkg::*;
#(
   parameter int SIGNALS = 64
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        push,
   output logic        full,
   input  logic        req_type,
   input  logic [7:0]  req_packet_length,
   input  logic [3:0]  req_packet_kind,
   input  logic [63:0] req_inverse_bits,
   input  logic [63:0] req_direct_bits,

   output logic        empty,
   input  logic        pop,
   output logic        rsp_publish_valid,
   output logic [63:0] rsp_signal_states,
   output logic        rsp_poll_request,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_error_changed,
   output logic [2:0]  rsp_mode,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int CMD_W   = $bits(cmd_type);
   localparam int CQ_W    = CMD_W + SIGNALS;
   localparam int RSP_W   = $bits(rsp_type);

   cfg_type            cfg_ff, cfg_in;
   cmd_type            fe_kind;
   logic [SIGNALS-1:0] fe_dir;
   logic [CQ_W-1:0]    cq_rd_data;
   logic               cq_empty;
   logic               cq_pop;
   cmd_type            be_kind;
   logic [SIGNALS-1:0] be_dir;
   logic               rq_full;
   logic               rq_push;
   rsp_type            be_rsp;
   logic [RSP_W-1:0]   rq_rd_data;
   rsp_type            out_rsp;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE: cfg_in.debounce_ms         = csr_data[15:0];
            CSR_RESP_TMO: cfg_in.response_timeout_ms = csr_data[23:0];
            CSR_ERR_TMO:  cfg_in.error_timeout_ms    = csr_data[23:0];
            CSR_ENABLE:   cfg_in.signal_enable_mask  = csr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms         <= DEBOUNCE_RESET;
         cfg_ff.response_timeout_ms <= RESP_TMO_RESET;
         cfg_ff.error_timeout_ms    <= ERR_TMO_RESET;
         cfg_ff.signal_enable_mask  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   didm_front #(
      .SIGNALS (SIGNALS)
   ) u_front (
      .req_type          (req_type),
      .req_packet_length (req_packet_length),
      .req_packet_kind   (req_packet_kind),
      .req_inverse_bits  (req_inverse_bits),
      .req_direct_bits   (req_direct_bits),
      .cmd_kind          (fe_kind),
      .cmd_dir           (fe_dir)
   );

   didm_fifo #(
      .WIDTH (CQ_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data ({fe_kind, fe_dir}),
      .full    (full),
      .rd_en   (cq_pop),
      .rd_data (cq_rd_data),
      .empty   (cq_empty)
   );

   assign be_kind = cmd_type'(cq_rd_data[SIGNALS +: CMD_W]);
   assign be_dir  = cq_rd_data[SIGNALS-1:0];

   didm_back #(
      .SIGNALS (SIGNALS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (!cq_empty),
      .cmd_kind  (be_kind),
      .cmd_dir   (be_dir),
      .cmd_pop   (cq_pop),
      .rsp_full  (rq_full),
      .rsp_push  (rq_push),
      .rsp       (be_rsp)
   );

   didm_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rq_push),
      .wr_data (be_rsp),
      .full    (rq_full),
      .rd_en   (pop),
      .rd_data (rq_rd_data),
      .empty   (empty)
   );

   assign out_rsp           = rsp_type'(rq_rd_data);
   assign rsp_publish_valid = out_rsp.publish_valid;
   assign rsp_signal_states = out_rsp.signal_states;
   assign rsp_poll_request  = out_rsp.poll_request;
   assign rsp_error_code    = out_rsp.error_code;
   assign rsp_error_changed = out_rsp.error_changed;
   assign rsp_mode          = out_rsp.mode;

endmodule

// File: hw/rtl/didm_fifo.sv
// ----------------------------------------------------------------------------
// didm_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module didm_fifo
   import didm_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: hw/rtl/didm_front.sv
// ----------------------------------------------------------------------------
// didm_front
// Classifies an incoming request: tick, short packet, wrong kind, code
// overlap or good data packet. Keeps only the existing signal bits.
// ----------------------------------------------------------------------------
module didm_front
   import didm_pkg::*;
#(
   parameter int SIGNALS = 64
) (
   input  logic               req_type,
   input  logic [7:0]         req_packet_length,
   input  logic [3:0]         req_packet_kind,
   input  logic [63:0]        req_inverse_bits,
   input  logic [63:0]        req_direct_bits,
   output cmd_type            cmd_kind,
   output logic [SIGNALS-1:0] cmd_dir
);

   logic [SIGNALS-1:0] inv;

   assign inv     = req_inverse_bits[63 -: SIGNALS];
   assign cmd_dir = req_direct_bits[63 -: SIGNALS];

   always_comb begin
      if (req_type == REQ_TICK) begin
         cmd_kind = CMD_TICK;
      end else if (req_packet_length < MIN_PACKET_LEN) begin
         cmd_kind = CMD_IGNORE;
      end else if (req_packet_kind != DATA_KIND) begin
         cmd_kind = CMD_CLEAR;
      end else if ((inv & cmd_dir) != '0) begin
         cmd_kind = CMD_OVERLAP;
      end else begin
         cmd_kind = CMD_DATA;
      end
   end

endmodule

// File: hw/rtl/didm_back.sv
// ----------------------------------------------------------------------------
// didm_back
// Mode sequencer: debounce, response and error timeouts, publication of
// the masked signal states and the elapsed-time counter.
// ----------------------------------------------------------------------------
module didm_back
   import didm_pkg::*;
#(
   parameter int SIGNALS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               cmd_valid,
   input  cmd_type            cmd_kind,
   input  logic [SIGNALS-1:0] cmd_dir,
   output logic               cmd_pop,
   input  logic               rsp_full,
   output logic               rsp_push,
   output rsp_type            rsp
);

   localparam int SIG_SHIFT = 64 - SIGNALS;

   mode_type           mode_ff, mode_in;
   err_type            error_ff, error_in;
   logic [SIGNALS-1:0] pending_ff, pending_in;
   logic [SIGNALS-1:0] published_ff, published_in;
   logic [23:0]        elapsed_ff, elapsed_in;
   logic [23:0]        elapsed_tick;
   logic               step;
   logic               differ;
   logic               ge_resp, ge_deb, ge_err;
   logic               publish;
   logic               poll;
   logic               err_set;
   err_type            err_val;
   logic [63:0]        pub_wide;

   assign step     = cmd_valid && !rsp_full;
   assign cmd_pop  = step;
   assign rsp_push = step;

   assign elapsed_tick = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 24'd1;
   assign ge_resp      = (elapsed_tick >= cfg.response_timeout_ms);
   assign ge_err       = (elapsed_tick >= cfg.error_timeout_ms);
   assign ge_deb       = (elapsed_tick >= {8'd0, cfg.debounce_ms});
   assign differ       = (published_ff != cmd_dir);

   // next mode
   always_comb begin
      mode_in = mode_ff;
      case (cmd_kind)
         CMD_OVERLAP: begin
            mode_in = MODE_ERROR;
         end
         CMD_DATA: begin
            case (mode_ff)
               MODE_WAIT:    mode_in = MODE_WAIT;
               MODE_TIMEOUT: mode_in = MODE_STEP;
               MODE_STEP: begin
                  if (differ && cfg.debounce_ms != 16'd0) begin
                     mode_in = MODE_WAIT;
                  end
               end
               default:      mode_in = MODE_STEP;
            endcase
         end
         CMD_TICK: begin
            case (mode_ff)
               MODE_STEP: begin
                  if (ge_resp) begin
                     mode_in = MODE_TIMEOUT;
                  end
               end
               MODE_WAIT: begin
                  if (ge_deb) begin
                     mode_in = MODE_STEP;
                  end
               end
               MODE_TIMEOUT: begin
                  if (ge_err) begin
                     mode_in = MODE_ERROR;
                  end
               end
               MODE_ERROR:   mode_in = MODE_ERROR;
               default:      mode_in = MODE_STEP;
            endcase
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   // datapath and result flags
   always_comb begin
      elapsed_in = elapsed_ff;
      pending_in = pending_ff;
      publish    = 1'b0;
      poll       = 1'b0;
      err_set    = 1'b0;
      err_val    = ERR_VALID;
      case (cmd_kind)
         CMD_CLEAR: begin
            elapsed_in = '0;
         end
         CMD_OVERLAP: begin
            elapsed_in = '0;
            err_set    = 1'b1;
            err_val    = ERR_INVALID;
         end
         CMD_DATA: begin
            elapsed_in = '0;
            case (mode_ff)
               MODE_WAIT: begin
                  pending_in = cmd_dir;
               end
               MODE_TIMEOUT: begin
                  if (differ) begin
                     pending_in = cmd_dir;
                     publish    = 1'b1;
                  end
                  err_set = 1'b1;
               end
               MODE_STEP: begin
                  if (differ) begin
                     pending_in = cmd_dir;
                     publish    = (cfg.debounce_ms == 16'd0);
                  end
               end
               default: begin
                  pending_in = cmd_dir;
                  publish    = 1'b1;
                  err_set    = 1'b1;
               end
            endcase
         end
         CMD_TICK: begin
            elapsed_in = elapsed_tick;
            case (mode_ff)
               MODE_STEP: begin
                  poll = ge_resp;
               end
               MODE_WAIT: begin
                  if (ge_deb) begin
                     publish = 1'b1;
                     err_set = 1'b1;
                  end
               end
               MODE_TIMEOUT: begin
                  poll = 1'b1;
                  if (ge_err) begin
                     err_set = 1'b1;
                     err_val = ERR_INVALID;
                  end
               end
               MODE_ERROR: begin
                  poll = 1'b1;
               end
               default: begin
                  poll = 1'b0;
               end
            endcase
         end
         default: begin
            elapsed_in = elapsed_ff;
         end
      endcase
   end

   assign published_in = publish ? pending_in : published_ff;
   assign error_in     = err_set ? err_val : error_ff;
   assign pub_wide     = 64'(published_in) << SIG_SHIFT;

   always_comb begin
      rsp.publish_valid = publish;
      rsp.signal_states = publish ? (pub_wide & cfg.signal_enable_mask) : 64'd0;
      rsp.poll_request  = poll;
      rsp.error_code    = error_in;
      rsp.error_changed = err_set && (err_val != error_ff);
      rsp.mode          = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_BEGIN;
         error_ff     <= ERR_UNKNOWN;
         pending_ff   <= '0;
         published_ff <= '0;
         elapsed_ff   <= '0;
      end else if (step) begin
         mode_ff      <= mode_in;
         error_ff     <= error_in;
         pending_ff   <= pending_in;
         published_ff <= published_in;
         elapsed_ff   <= elapsed_in;
      end
   end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the discrete input debounce monitor.
// ----------------------------------------------------------------------------
// Requests are queued by the stimulus process and offered by a clocked
// driver. Each accepted request goes through a local model of the debounce
// and supervision modes, and its result is queued. A clocked monitor pops
// results and compares them field by field. The run steps through several
// register settings, with random stalls on both sides, long hold-offs on the
// result side and a final phase free of stalls.
// ----------------------------------------------------------------------------
module testbench;
   import didm_pkg::*;

   localparam int          SIGNALS      = 64;
   localparam logic [63:0] SIG_MASK     = ~((64'd1 << (64 - SIGNALS)) - 64'd1);
   localparam logic [63:0] ALL_ONES     = '1;
   localparam logic [7:0]  CSR_UNUSED   = 8'd200;
   localparam int          LIMIT_CYCLES = 400000;
   localparam int          HOLD_CYCLES  = 80;

   typedef struct packed {
      logic        is_tick;
      logic [7:0]  length;
      logic [3:0]  nibble;
      logic [63:0] inverse;
      logic [63:0] direct;
   } telesig_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_type = 1'b0;
   logic [7:0]  req_packet_length = '0;
   logic [3:0]  req_packet_kind = '0;
   logic [63:0] req_inverse_bits = '0;
   logic [63:0] req_direct_bits = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_publish_valid;
   logic [63:0] rsp_signal_states;
   logic        rsp_poll_request;
   logic [1:0]  rsp_error_code;
   logic        rsp_error_changed;
   logic [2:0]  rsp_mode;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   discrete_input_debounce_monitor #(.SIGNALS(SIGNALS)) uut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_type          (req_type),
      .req_packet_length (req_packet_length),
      .req_packet_kind   (req_packet_kind),
      .req_inverse_bits  (req_inverse_bits),
      .req_direct_bits   (req_direct_bits),
      .empty             (empty),
      .pop               (pop),
      .rsp_publish_valid (rsp_publish_valid),
      .rsp_signal_states (rsp_signal_states),
      .rsp_poll_request  (rsp_poll_request),
      .rsp_error_code    (rsp_error_code),
      .rsp_error_changed (rsp_error_changed),
      .rsp_mode          (rsp_mode),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // local copy of registers and supervision state
   cfg_type     csr_shadow = '{DEBOUNCE_RESET, RESP_TMO_RESET, ERR_TMO_RESET, 64'd0};
   mode_type    sup_mode = MODE_BEGIN;
   logic [63:0] pending_bits = '0;
   logic [63:0] published_bits = '0;
   logic [23:0] elapsed_ms = '0;
   err_type     link_error = ERR_UNKNOWN;
   logic        error_flipped = 1'b0;

   telesig_req_type pending_reqs[$];
   rsp_type         expected_rsps[$];
   telesig_req_type offer;
   int              gap_pct = 0;
   int              drv_gap = 0;
   int              mon_gap = 0;
   int              hold_left = 0;
   int              rsp_count = 0;
   int              fail_count = 0;
   int              cycles = 0;

   function automatic void flag_error(err_type code);
      if (link_error != code) begin
         link_error = code;
         error_flipped = 1'b1;
      end
   endfunction

   function automatic rsp_type debounce_step(telesig_req_type rq);
      rsp_type     res;
      logic        announce;
      logic [63:0] inv;
      logic [63:0] dir;
      res = '0;
      announce = 1'b0;
      error_flipped = 1'b0;
      inv = rq.inverse & SIG_MASK;
      dir = rq.direct & SIG_MASK;
      if (rq.is_tick == REQ_TICK) begin
         if (elapsed_ms != ELAPSED_MAX) elapsed_ms = elapsed_ms + 24'd1;
         case (sup_mode)
            MODE_STEP: begin
               if (elapsed_ms >= csr_shadow.response_timeout_ms) begin
                  sup_mode = MODE_TIMEOUT;
                  res.poll_request = 1'b1;
               end
            end
            MODE_WAIT: begin
               if (elapsed_ms >= {8'd0, csr_shadow.debounce_ms}) begin
                  sup_mode = MODE_STEP;
                  published_bits = pending_bits;
                  announce = 1'b1;
                  flag_error(ERR_VALID);
               end
            end
            MODE_TIMEOUT: begin
               if (elapsed_ms >= csr_shadow.error_timeout_ms) begin
                  flag_error(ERR_INVALID);
                  sup_mode = MODE_ERROR;
               end
               res.poll_request = 1'b1;
            end
            MODE_ERROR: res.poll_request = 1'b1;
            default: sup_mode = MODE_STEP;
         endcase
      end else if (rq.length >= MIN_PACKET_LEN) begin
         elapsed_ms = '0;
         if (rq.nibble == DATA_KIND) begin
            if ((inv & dir) != 64'd0) begin
               flag_error(ERR_INVALID);
               sup_mode = MODE_ERROR;
            end else begin
               case (sup_mode)
                  MODE_WAIT: pending_bits = dir;
                  MODE_TIMEOUT: begin
                     sup_mode = MODE_STEP;
                     if (published_bits != dir) begin
                        pending_bits = dir;
                        published_bits = dir;
                        announce = 1'b1;
                     end
                     flag_error(ERR_VALID);
                  end
                  MODE_STEP: begin
                     if (published_bits != dir) begin
                        pending_bits = dir;
                        if (csr_shadow.debounce_ms == 16'd0) begin
                           published_bits = dir;
                           announce = 1'b1;
                        end else begin
                           sup_mode = MODE_WAIT;
                        end
                     end
                  end
                  default: begin
                     sup_mode = MODE_STEP;
                     pending_bits = dir;
                     published_bits = dir;
                     announce = 1'b1;
                     flag_error(ERR_VALID);
                  end
               endcase
            end
         end
      end
      res.publish_valid = announce;
      res.signal_states = announce ? (published_bits & csr_shadow.signal_enable_mask) : '0;
      res.error_code = link_error;
      res.error_changed = error_flipped;
      res.mode = sup_mode;
      return res;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic telesig_req_type make_packet(logic [7:0] len, logic [3:0] nib,
                                                   logic [63:0] inv, logic [63:0] dir);
      return '{REQ_PACKET, len, nib, inv, dir};
   endfunction

   function automatic telesig_req_type make_tick();
      return '{REQ_TICK, 8'(rand64()), 4'(rand64()), rand64(), rand64()};
   endfunction

   // driver: offers queued requests, models each one as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            expected_rsps.push_back(debounce_step(offer));
         end
         if (!push || !full) begin
            if (drv_gap > 0) begin
               drv_gap--;
               push <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
               push <= 1'b0;
            end else if ($urandom_range(99) < gap_pct) begin
               drv_gap = $urandom_range(8);
               push <= 1'b0;
            end else begin
               offer = pending_reqs.pop_front();
               push <= 1'b1;
               req_type <= offer.is_tick;
               req_packet_length <= offer.length;
               req_packet_kind <= offer.nibble;
               req_inverse_bits <= offer.inverse;
               req_direct_bits <= offer.direct;
            end
         end
      end
   end

   // monitor: pops results and checks them against the model
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: result expected none actual mode %0d", $time, rsp_mode);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("publish_valid", 64'(want.publish_valid), 64'(rsp_publish_valid));
               check_field("signal_states", want.signal_states, rsp_signal_states);
               check_field("poll_request", 64'(want.poll_request), 64'(rsp_poll_request));
               check_field("error_code", 64'(want.error_code), 64'(rsp_error_code));
               check_field("error_changed", 64'(want.error_changed), 64'(rsp_error_changed));
               check_field("mode", 64'(want.mode), 64'(rsp_mode));
            end
            rsp_count++;
            if (rsp_count == 150 || rsp_count == 850) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (mon_gap > 0) begin
            mon_gap--;
            pop <= 1'b0;
         end else if ($urandom_range(99) < gap_pct) begin
            mon_gap = $urandom_range(8);
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_csr(logic [7:0] idx, logic [63:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DEBOUNCE: csr_shadow.debounce_ms = data[15:0];
         CSR_RESP_TMO: csr_shadow.response_timeout_ms = data[23:0];
         CSR_ERR_TMO:  csr_shadow.error_timeout_ms = data[23:0];
         CSR_ENABLE:   csr_shadow.signal_enable_mask = data;
         default: ;
      endcase
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || push || expected_rsps.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // mostly clean packets from a slowly changing pattern, runs of ticks,
   // and some short, wrong-kind and overlapping packets
   task automatic random_phase(int n, int gap, int span);
      int          made;
      int          pick;
      int          run;
      int          bit_no;
      logic [3:0]  nib;
      logic [63:0] last_dir;
      logic [63:0] dir;
      logic [63:0] inv;
      made = 0;
      last_dir = rand64();
      gap_pct <= gap;
      while (made < n) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            run = $urandom_range(1, span);
            repeat (run) pending_reqs.push_back(make_tick());
            made += run;
         end else if (pick < 82) begin
            case ($urandom_range(3))
               0: last_dir = rand64();
               1: last_dir ^= 64'd1 << $urandom_range(63);
               default: ;
            endcase
            inv = ~last_dir;
            if ($urandom_range(3) == 0) inv &= rand64();
            pending_reqs.push_back(make_packet(8'($urandom_range(21, 255)), DATA_KIND, inv,
                                               last_dir));
            made++;
         end else if (pick < 89) begin
            pending_reqs.push_back(make_packet(8'($urandom_range(20)), 4'($urandom_range(15)),
                                               rand64(), rand64()));
         end else if (pick < 94) begin
            nib = 4'($urandom_range(15));
            if (nib == DATA_KIND) nib = nib + 4'd1;
            pending_reqs.push_back(make_packet(8'($urandom_range(21, 255)), nib, rand64(),
                                               rand64()));
            made++;
         end else begin
            bit_no = $urandom_range(63);
            dir = rand64() | (64'd1 << bit_no);
            inv = rand64() | (64'd1 << bit_no);
            pending_reqs.push_back(make_packet(8'($urandom_range(21, 255)), DATA_KIND, inv,
                                               dir));
            made++;
         end
      end
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // register values out of reset
      pending_reqs.push_back(make_tick());
      pending_reqs.push_back(make_packet(8'd0, DATA_KIND, 64'd0, ALL_ONES));
      pending_reqs.push_back(make_packet(8'd20, DATA_KIND, 64'd0, ALL_ONES));
      pending_reqs.push_back(make_packet(8'd21, DATA_KIND, 64'hAAAA_AAAA_AAAA_AAAA,
                                         64'h5555_5555_5555_5555));
      pending_reqs.push_back(make_packet(8'd255, 4'd15, 64'h5555_5555_5555_5555,
                                         64'hAAAA_AAAA_AAAA_AAAA));
      pending_reqs.push_back(make_packet(8'd21, DATA_KIND, 64'd1, 64'd1));
      pending_reqs.push_back(make_packet(8'd255, DATA_KIND, 64'd0, ALL_ONES));
      drain();

      write_csr(CSR_DEBOUNCE, 64'd0);
      write_csr(CSR_RESP_TMO, 64'd3);
      write_csr(CSR_ERR_TMO, 64'd6);
      write_csr(CSR_ENABLE, ALL_ONES);
      write_csr(CSR_UNUSED, rand64());

      // timeout, recovery without change, error by silence, overlap
      pending_reqs.push_back(make_packet(8'd255, 4'd0, ALL_ONES, 64'd0));
      repeat (3) pending_reqs.push_back(make_tick());
      pending_reqs.push_back(make_packet(8'd30, DATA_KIND, 64'd0, ALL_ONES));
      repeat (7) pending_reqs.push_back(make_tick());
      pending_reqs.push_back(make_packet(8'd21, DATA_KIND, ALL_ONES, 64'd0));
      pending_reqs.push_back(make_packet(8'd21, DATA_KIND, ALL_ONES, ALL_ONES));
      pending_reqs.push_back(make_packet(8'd64, DATA_KIND, 64'h0000_0000_FFFF_FFFF,
                                         64'hFFFF_FFFF_0000_0000));
      repeat (3) pending_reqs.push_back(make_tick());
      pending_reqs.push_back(make_packet(8'd64, DATA_KIND, 64'hF0F0_F0F0_F0F0_F0F0,
                                         64'h0F0F_0F0F_0F0F_0F0F));
      drain();

      write_csr(CSR_DEBOUNCE, 64'd2);
      write_csr(CSR_RESP_TMO, 64'd5);
      write_csr(CSR_ERR_TMO, 64'd9);
      write_csr(CSR_ENABLE, rand64());
      random_phase(350, 15, 12);

      write_csr(CSR_DEBOUNCE, 64'd0);
      write_csr(CSR_RESP_TMO, 64'd0);
      write_csr(CSR_ERR_TMO, 64'd0);
      write_csr(CSR_ENABLE, ALL_ONES);
      random_phase(350, 30, 4);

      write_csr(CSR_DEBOUNCE, 64'hFFFF);
      write_csr(CSR_RESP_TMO, 64'hFF_FFFF);
      write_csr(CSR_ERR_TMO, 64'hFF_FFFF);
      write_csr(CSR_ENABLE, 64'd0);
      random_phase(350, 0, 6);

      write_csr(CSR_DEBOUNCE, (rand64() << 16) | 64'($urandom_range(1, 6)));
      write_csr(CSR_RESP_TMO, (rand64() << 24) | 64'($urandom_range(3, 20)));
      write_csr(CSR_ERR_TMO, (rand64() << 24) | 64'($urandom_range(30)));
      write_csr(CSR_ENABLE, rand64());
      random_phase(350, 20, 30);

      // final stretch, no stalls
      write_csr(CSR_DEBOUNCE, 64'd1);
      write_csr(CSR_RESP_TMO, 64'd4);
      write_csr(CSR_ERR_TMO, 64'd2);
      write_csr(CSR_ENABLE, ALL_ONES);
      random_phase(350, 0, 8);

      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
